// File: hw/rtl/ckx_pkg.sv
`timescale 1ns / 1ps
// Package for the keyed XOR stream cipher: constants, command and status types,
// controller states and the twister output tempering function. No dependencies.
package ckx_pkg;

	localparam int unsigned TWISTER_DEPTH_DEF = 312;

	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_PASS  = 2'd1;
	localparam logic [1:0] MODE_DATA  = 2'd2;

	localparam logic [63:0] FNV_BASIS  = 64'h14650FB0739D0383;
	localparam logic [8:0]  FNV_MUL_LO = 9'h1B3;
	localparam int unsigned FNV_MUL_SH = 40;

	localparam logic [63:0] MIX_C0  = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX_C1  = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX_C2  = 64'h94D049BB133111EB;
	localparam logic [63:0] LCG_MUL = 64'h5851F42D4C957F2D;
	localparam logic [63:0] MT_MAG  = 64'hB5026F5AA96619E9;

	localparam logic [1:0] MUL_PH_FIRST = 2'd0;
	localparam logic [1:0] MUL_PH_MID   = 2'd1;
	localparam logic [1:0] MUL_PH_LAST  = 2'd2;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_LDN,
		ACC_XH,
		ACC_ADD,
		ACC_XS30,
		ACC_XS27,
		ACC_XS31,
		ACC_XS62
	} acc_op_t;

	typedef enum logic [1:0] {
		MUL_C1,
		MUL_C2,
		MUL_LCG
	} mul_sel_t;

	typedef enum logic [1:0] {
		RD_ZERO,
		RD_K1,
		RD_KSH,
		RD_TIDX
	} rd_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MX_LDN,
		ST_MX_ADD,
		ST_MX_S30,
		ST_MX_M1,
		ST_MX_S27,
		ST_MX_M2,
		ST_MX_S31,
		ST_MX_XH,
		ST_SD_S62,
		ST_SD_MUL,
		ST_SD_WR,
		ST_NX_CHK,
		ST_RG_L0,
		ST_RG_C0,
		ST_RG_R1,
		ST_RG_R2,
		ST_RG_W,
		ST_NX_RD,
		ST_NX_TM,
		ST_EMIT
	} ckx_state_t;

	typedef struct packed {
		logic     take;
		acc_op_t  acc_op;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     cnt_clr;
		logic     seed_wr;
		logic     seed_done;
		rd_sel_t  rd_sel;
		logic     cur_ld;
		logic     nxt_ld;
		logic     rg_wr;
		logic     key_ld;
		logic     emit;
	} ckx_cmd_t;

	typedef struct packed {
		logic kready;
		logic bpos_zero;
		logic tidx_full;
		logic cnt_last;
		logic mul_done;
	} ckx_sts_t;

	function automatic logic [63:0] ckx_temper(input logic [63:0] x);
		logic [63:0] y;
		y = x;
		y = y ^ ((y >> 29) & 64'h5555555555555555);
		y = y ^ ((y << 17) & 64'h71D6A4A7FFFEEEF7);
		y = y ^ ((y << 37) & 64'hFFF7EEE000000000);
		y = y ^ (y >> 43);
		return y;
	endfunction

endpackage

// File: hw/rtl/ckx_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ckx_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 312
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hw/rtl/ckx_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences hashing, seed mixing, twister seeding, regeneration and
// byte output. Depends on ckx_pkg.
module ckx_ctrl
	import ckx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	output logic       out_valid,
	input  logic       out_ready,
	input  ckx_sts_t   sts,
	output ckx_cmd_t   cmd
);

	ckx_state_t state_q, state_d;
	logic       pass_q, pass_d;
	logic       out_valid_q;
	logic       take;
	logic       emit_ok;

	assign in_ready  = (state_q == ST_IDLE);
	assign take      = in_valid && in_ready;
	assign emit_ok   = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		pass_d  = pass_q;
		case (state_q)
			ST_IDLE: begin
				if (take && mode == MODE_DATA) begin
					if (!sts.kready) begin
						state_d = ST_MX_LDN;
					end else if (sts.bpos_zero) begin
						state_d = ST_NX_CHK;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_MX_LDN: begin
				pass_d  = 1'b0;
				state_d = ST_MX_ADD;
			end
			ST_MX_ADD: state_d = ST_MX_S30;
			ST_MX_S30: state_d = ST_MX_M1;
			ST_MX_M1:  if (sts.mul_done) state_d = ST_MX_S27;
			ST_MX_S27: state_d = ST_MX_M2;
			ST_MX_M2:  if (sts.mul_done) state_d = ST_MX_S31;
			ST_MX_S31: state_d = pass_q ? ST_SD_WR : ST_MX_XH;
			ST_MX_XH: begin
				pass_d  = 1'b1;
				state_d = ST_MX_ADD;
			end
			ST_SD_S62: state_d = ST_SD_MUL;
			ST_SD_MUL: if (sts.mul_done) state_d = ST_SD_WR;
			ST_SD_WR:  state_d = sts.cnt_last ? ST_NX_CHK : ST_SD_S62;
			ST_NX_CHK: state_d = sts.tidx_full ? ST_RG_L0 : ST_NX_RD;
			ST_RG_L0:  state_d = ST_RG_C0;
			ST_RG_C0:  state_d = ST_RG_R1;
			ST_RG_R1:  state_d = ST_RG_R2;
			ST_RG_R2:  state_d = ST_RG_W;
			ST_RG_W:   state_d = sts.cnt_last ? ST_NX_RD : ST_RG_R1;
			ST_NX_RD:  state_d = ST_NX_TM;
			ST_NX_TM:  state_d = ST_EMIT;
			ST_EMIT:   if (emit_ok) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.acc_op  = ACC_HOLD;
		cmd.mul_sel = MUL_C1;
		cmd.rd_sel  = RD_ZERO;
		cmd.take    = take;
		case (state_q)
			ST_MX_LDN: cmd.acc_op = ACC_LDN;
			ST_MX_ADD: cmd.acc_op = ACC_ADD;
			ST_MX_S30: cmd.acc_op = ACC_XS30;
			ST_MX_M1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_C1;
			end
			ST_MX_S27: cmd.acc_op = ACC_XS27;
			ST_MX_M2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_C2;
			end
			ST_MX_S31: begin
				cmd.acc_op  = ACC_XS31;
				cmd.cnt_clr = 1'b1;
			end
			ST_MX_XH:  cmd.acc_op = ACC_XH;
			ST_SD_S62: cmd.acc_op = ACC_XS62;
			ST_SD_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_LCG;
			end
			ST_SD_WR: begin
				cmd.seed_wr   = 1'b1;
				cmd.seed_done = sts.cnt_last;
			end
			ST_RG_L0: begin
				cmd.cnt_clr = 1'b1;
				cmd.rd_sel  = RD_ZERO;
			end
			ST_RG_C0: cmd.cur_ld = 1'b1;
			ST_RG_R1: cmd.rd_sel = RD_K1;
			ST_RG_R2: begin
				cmd.nxt_ld = 1'b1;
				cmd.rd_sel = RD_KSH;
			end
			ST_RG_W:  cmd.rg_wr = 1'b1;
			ST_NX_RD: cmd.rd_sel = RD_TIDX;
			ST_NX_TM: cmd.key_ld = 1'b1;
			ST_EMIT:  cmd.emit = emit_ok;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pass_q  <= pass_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: hw/rtl/ckx_dp.sv
`timescale 1ns / 1ps
// Datapath: nonce and hash registers, shared 32x32 multiplier, twister word
// store, tempering and byte output. Depends on ckx_pkg and ckx_ram.
module ckx_dp
	import ckx_pkg::*;
#(
	parameter int unsigned TWISTER_DEPTH = TWISTER_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	input  logic [1:0]  mode,
	input  logic [7:0]  value,
	input  ckx_cmd_t    cmd,
	output ckx_sts_t    sts,
	output logic [7:0]  data_out
);

	localparam int unsigned AW    = $clog2(TWISTER_DEPTH);
	localparam int unsigned CW    = $clog2(TWISTER_DEPTH + 1);
	localparam int unsigned SHIFT = TWISTER_DEPTH / 2;

	logic [63:0]   nonce_q, hash_q, acc_q, macc_q, keyw_q, cur_q, nxt_q;
	logic [7:0]    val_q, data_out_q;
	logic [2:0]    bpos_q;
	logic          kready_q;
	logic [CW-1:0] tidx_q, cnt_q;
	logic [1:0]    mph_q;

	logic [63:0]   hx, bconst, prod, seed_val, rdata, wdata, y, v;
	logic [31:0]   a_op, b_op;
	logic [CW:0]   ksh;
	logic [AW-1:0] raddr, k1_addr, ksh_addr;
	logic          we;

	assign hx = hash_q ^ {56'd0, value};

	always_comb begin
		case (cmd.mul_sel)
			MUL_C1:  bconst = MIX_C1;
			MUL_C2:  bconst = MIX_C2;
			MUL_LCG: bconst = LCG_MUL;
			default: bconst = MIX_C1;
		endcase
	end

	assign a_op = (mph_q == MUL_PH_LAST) ? acc_q[63:32] : acc_q[31:0];
	assign b_op = (mph_q == MUL_PH_MID) ? bconst[63:32] : bconst[31:0];
	assign prod = {32'd0, a_op} * {32'd0, b_op};

	assign seed_val = acc_q + {{(64 - CW){1'b0}}, cnt_q};

	assign k1_addr  = (cnt_q == CW'(TWISTER_DEPTH - 1)) ? '0 : AW'(cnt_q + 1'b1);
	assign ksh      = {1'b0, cnt_q} + (CW + 1)'(SHIFT);
	assign ksh_addr = (ksh >= (CW + 1)'(TWISTER_DEPTH)) ?
		AW'(ksh - (CW + 1)'(TWISTER_DEPTH)) : AW'(ksh);

	always_comb begin
		case (cmd.rd_sel)
			RD_ZERO: raddr = '0;
			RD_K1:   raddr = k1_addr;
			RD_KSH:  raddr = ksh_addr;
			RD_TIDX: raddr = tidx_q[AW-1:0];
			default: raddr = '0;
		endcase
	end

	assign y     = {cur_q[63:31], nxt_q[30:0]};
	assign v     = rdata ^ (y >> 1) ^ (y[0] ? MT_MAG : 64'd0);
	assign we    = cmd.seed_wr || cmd.rg_wr;
	assign wdata = cmd.seed_wr ? seed_val : v;

	ckx_ram #(
		.WIDTH(64),
		.DEPTH(TWISTER_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(cnt_q[AW-1:0]),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonce_q  <= '0;
			hash_q   <= FNV_BASIS;
			kready_q <= 1'b0;
			bpos_q   <= '0;
			tidx_q   <= '0;
			mph_q    <= MUL_PH_FIRST;
		end else begin
			if (cfg_we) begin
				nonce_q <= cfg_wdata;
			end
			if (cmd.take) begin
				case (mode)
					MODE_START: begin
						hash_q   <= FNV_BASIS;
						kready_q <= 1'b0;
						bpos_q   <= '0;
					end
					MODE_PASS: hash_q <= (hx << FNV_MUL_SH) + (hx * {55'd0, FNV_MUL_LO});
					default: ;
				endcase
			end
			if (cmd.mul_en) begin
				mph_q <= (mph_q == MUL_PH_LAST) ? MUL_PH_FIRST : mph_q + 2'd1;
			end
			if (cmd.seed_done) begin
				kready_q <= 1'b1;
				bpos_q   <= '0;
				tidx_q   <= CW'(TWISTER_DEPTH);
			end
			if (cmd.rg_wr && sts.cnt_last) begin
				tidx_q <= '0;
			end
			if (cmd.key_ld) begin
				tidx_q <= tidx_q + 1'b1;
			end
			if (cmd.emit) begin
				bpos_q <= bpos_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			val_q <= value;
		end
		case (cmd.acc_op)
			ACC_LDN:  acc_q <= nonce_q;
			ACC_XH:   acc_q <= acc_q ^ hash_q;
			ACC_ADD:  acc_q <= acc_q + MIX_C0;
			ACC_XS30: acc_q <= acc_q ^ (acc_q >> 30);
			ACC_XS27: acc_q <= acc_q ^ (acc_q >> 27);
			ACC_XS31: acc_q <= acc_q ^ (acc_q >> 31);
			ACC_XS62: acc_q <= acc_q ^ (acc_q >> 62);
			default: ;
		endcase
		if (cmd.mul_en) begin
			case (mph_q)
				MUL_PH_FIRST: macc_q <= prod;
				MUL_PH_MID:   macc_q <= macc_q + {prod[31:0], 32'd0};
				default:      acc_q  <= macc_q + {prod[31:0], 32'd0};
			endcase
		end
		if (cmd.seed_wr) begin
			acc_q <= seed_val;
		end
		if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.seed_wr || cmd.rg_wr) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.cur_ld) begin
			cur_q <= rdata;
		end
		if (cmd.nxt_ld) begin
			nxt_q <= rdata;
		end
		if (cmd.rg_wr) begin
			cur_q <= nxt_q;
		end
		if (cmd.key_ld) begin
			keyw_q <= ckx_temper(rdata);
		end
		if (cmd.emit) begin
			data_out_q <= val_q ^ keyw_q[{bpos_q, 3'b000} +: 8];
		end
	end

	assign sts.kready    = kready_q;
	assign sts.bpos_zero = (bpos_q == 3'd0);
	assign sts.tidx_full = (tidx_q >= CW'(TWISTER_DEPTH));
	assign sts.cnt_last  = (cnt_q == CW'(TWISTER_DEPTH - 1));
	assign sts.mul_done  = cmd.mul_en && (mph_q == MUL_PH_LAST);

	assign data_out = data_out_q;

endmodule

// File: hw/rtl/password_keyed_xor_stream_cipher.sv
`timescale 1ns / 1ps
// Top level of the password-keyed XOR stream cipher on a 64-bit Mersenne Twister.
// Depends on ckx_pkg, ckx_ctrl, ckx_dp and ckx_ram.
//
//  channel  handshake               payload
//  in       in_valid / in_ready     mode[1:0], value[7:0]
//  out      out_valid / out_ready   data_out[7:0]
//  cfg      cfg_we                  cfg_wdata[63:0] (nonce)
//
// A data byte uses a byte of the held key word; every eighth byte first reads and
// tempers a new twister word, and the 312-word store regenerates once all its
// words are used. The first data byte after a start first seeds the store: the nonce
// and hash are mixed, then each word is written, on the one 32x32 multiplier.
// Reset sets the hash to its basis and clears the key state and indexes; the store
// needs no clearing. A result waiting on out_ready holds only the final output
// step; input is taken again as soon as the controller returns to idle.
module password_keyed_xor_stream_cipher
	import ckx_pkg::*;
#(
	parameter int unsigned TWISTER_DEPTH = TWISTER_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  data_out,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata
);

	ckx_cmd_t cmd;
	ckx_sts_t sts;

	ckx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ckx_dp #(
		.TWISTER_DEPTH(TWISTER_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.mode     (mode),
		.value    (value),
		.cmd      (cmd),
		.sts      (sts),
		.data_out (data_out)
	);

endmodule

// File: verif/password_keyed_xor_stream_cipher_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for password_keyed_xor_stream_cipher: a directed table, then
// random password/data sessions over several nonces, checked against a local cipher model.
// Depends on ckx_pkg and the cipher RTL.
module password_keyed_xor_stream_cipher_tb;
	import ckx_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int MT_N = 312;
	localparam int MT_HALF = 156;
	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE = 20;

	typedef struct {
		logic [1:0] md;
		logic [7:0] val;
		bit         silent;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  mode;
	logic [7:0]  value;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  data_out;
	logic        cfg_we;
	logic [63:0] cfg_wdata;

	logic [7:0]  cipher_q[$];
	int          errors;
	int          results_seen;
	bit          calm;

	logic [63:0] nonce_m;
	logic [63:0] hash_m;
	bit          keyed_m;
	logic [63:0] mt_words[MT_N];
	int          mt_idx;
	logic [63:0] key_word_m;
	logic [2:0]  byte_ix;

	stim_row_t   dir_rows[20];

	password_keyed_xor_stream_cipher dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode), .value(value),
		.out_valid(out_valid), .out_ready(out_ready), .data_out(data_out),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic logic [63:0] splitmix(input logic [63:0] v);
		logic [63:0] x;
		x = v + 64'h9E3779B97F4A7C15;
		x = (x ^ (x >> 30)) * 64'hBF58476D1CE4E5B9;
		x = (x ^ (x >> 27)) * 64'h94D049BB133111EB;
		return x ^ (x >> 31);
	endfunction

	task automatic mt_seed(input logic [63:0] s);
		logic [63:0] p;
		mt_words[0] = s;
		for (int k = 1; k < MT_N; k++) begin
			p = mt_words[k-1];
			mt_words[k] = 64'h5851F42D4C957F2D * (p ^ (p >> 62)) + 64'(k);
		end
		mt_idx = MT_N;
	endtask

	task automatic mt_regen();
		logic [63:0] y;
		logic [63:0] v;
		for (int k = 0; k < MT_N; k++) begin
			y = (mt_words[k] & 64'hFFFFFFFF80000000) |
				(mt_words[(k + 1) % MT_N] & 64'h7FFFFFFF);
			v = mt_words[(k + MT_HALF) % MT_N] ^ (y >> 1);
			if (y[0]) begin
				v = v ^ 64'hB5026F5AA96619E9;
			end
			mt_words[k] = v;
		end
		mt_idx = 0;
	endtask

	task automatic mt_draw(output logic [63:0] w);
		logic [63:0] y;
		if (mt_idx >= MT_N) begin
			mt_regen();
		end
		y = mt_words[mt_idx];
		mt_idx++;
		y = y ^ ((y >> 29) & 64'h5555555555555555);
		y = y ^ ((y << 17) & 64'h71D6A4A7FFFEEEF7);
		y = y ^ ((y << 37) & 64'hFFF7EEE000000000);
		w = y ^ (y >> 43);
	endtask

	task automatic cipher_step(input logic [1:0] md, input logic [7:0] val, output bit has,
			output logic [7:0] ct);
		has = 1'b0;
		ct = 8'h00;
		case (md)
			MODE_START: begin
				hash_m = FNV_BASIS;
				keyed_m = 1'b0;
				byte_ix = 3'd0;
			end
			MODE_PASS: begin
				hash_m = (hash_m ^ {56'd0, val}) * 64'd1099511628211;
			end
			MODE_DATA: begin
				if (!keyed_m) begin
					mt_seed(splitmix(hash_m ^ splitmix(nonce_m)));
					keyed_m = 1'b1;
					byte_ix = 3'd0;
				end
				if (byte_ix == 3'd0) begin
					mt_draw(key_word_m);
				end
				ct = val ^ key_word_m[8*byte_ix +: 8];
				byte_ix = byte_ix + 3'd1;
				has = 1'b1;
			end
			default: ;
		endcase
	endtask

	function automatic int pick_gap();
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 9);
		if (r < 6) begin
			return 0;
		end
		if (r < 9) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// Offer one item, hold it until taken, then queue its predicted cipher byte, if it has one.
	task automatic send_item(input logic [1:0] md, input logic [7:0] val, output bit has);
		int gap;
		logic [7:0] ct;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= md;
		value <= val;
		do @(posedge clk); while (!in_ready);
		cipher_step(md, val, has, ct);
		if (has) begin
			cipher_q.push_back(ct);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (cipher_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_nonce(input logic [63:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		nonce_m = v;
	endtask

	task automatic run_session(inout int sent);
		bit has;
		int npw;
		int ndata;
		if ($urandom_range(0, 9) < 8) begin
			send_item(MODE_START, 8'($urandom), has);
			npw = $urandom_range(0, 8);
			repeat (npw) send_item(MODE_PASS, 8'($urandom), has);
			ndata = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) :
				$urandom_range(1, 12);
			for (int i = 0; i < ndata; i++) begin
				case ($urandom_range(0, 19))
					0: send_item(MODE_UNUSED, 8'($urandom), has);
					1: send_item(MODE_PASS, 8'($urandom), has);
					default: send_item(MODE_DATA, 8'($urandom), has);
				endcase
			end
			sent += 1 + npw + ndata;
		end else begin
			repeat (4) send_item(2'($urandom), 8'($urandom), has);
			sent += 4;
		end
	endtask

	// Receiver: random back-pressure, one long hold-off, compare each byte in order.
	initial begin
		int hold;
		int tick;
		logic [7:0] want;
		hold = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (cipher_q.size() == 0) begin
					report($sformatf("unexpected item data_out=%02h", data_out));
				end else begin
					want = cipher_q.pop_front();
					if (data_out !== want) begin
						report($sformatf("data_out=%02h want %02h", data_out, want));
					end
				end
				results_seen++;
				if (results_seen == 40) begin
					hold = 500;
				end
			end
			tick++;
			if (tick % 256 == 0) begin
				calm = ($urandom_range(0, 3) == 0);
			end
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				hold = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) :
					$urandom_range(1, 3);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle = 0;
			end else begin
				idle++;
			end
			if (idle >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		bit has;
		int sent;
		logic [63:0] nonces[5];
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_START;
		value = 8'h00;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 64'd0;
		errors = 0;
		results_seen = 0;
		calm = 1'b0;
		nonce_m = 64'd0;
		hash_m = FNV_BASIS;
		keyed_m = 1'b0;
		mt_idx = 0;
		key_word_m = 64'd0;
		byte_ix = 3'd0;
		dir_rows = '{
			'{MODE_DATA,   8'h00, 1'b0}, '{MODE_DATA,   8'hFF, 1'b0},
			'{MODE_UNUSED, 8'hFF, 1'b1}, '{MODE_UNUSED, 8'h00, 1'b1},
			'{MODE_PASS,   8'h00, 1'b1}, '{MODE_DATA,   8'h5A, 1'b0},
			'{MODE_START,  8'hFF, 1'b1}, '{MODE_PASS,   8'h00, 1'b1},
			'{MODE_PASS,   8'hFF, 1'b1}, '{MODE_PASS,   8'h61, 1'b1},
			'{MODE_DATA,   8'h00, 1'b0}, '{MODE_DATA,   8'hFF, 1'b0},
			'{MODE_DATA,   8'h00, 1'b0}, '{MODE_DATA,   8'hA5, 1'b0},
			'{MODE_DATA,   8'h00, 1'b0}, '{MODE_DATA,   8'hFF, 1'b0},
			'{MODE_DATA,   8'h00, 1'b0}, '{MODE_DATA,   8'h3C, 1'b0},
			'{MODE_START,  8'h00, 1'b1}, '{MODE_DATA,   8'hFF, 1'b0}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].md, dir_rows[i].val, has);
			if (has == dir_rows[i].silent) begin
				report($sformatf("row %0d result presence", i));
			end
		end
		drain();

		nonces[0] = 64'hFFFFFFFFFFFFFFFF;
		nonces[1] = {$urandom, $urandom};
		nonces[2] = 64'd1;
		nonces[3] = 64'h8000000000000000;
		nonces[4] = {$urandom, $urandom};
		foreach (nonces[p]) begin
			set_nonce(nonces[p]);
			// first item keeps the running key to exercise a nonce change mid-key
			send_item(MODE_DATA, 8'($urandom), has);
			sent = 0;
			while (sent < 150) run_session(sent);
			drain();
		end

		// one long key drawn over many twister words
		set_nonce(64'd0);
		send_item(MODE_START, 8'h00, has);
		repeat (3) send_item(MODE_PASS, 8'($urandom), has);
		repeat (1000) send_item(MODE_DATA, 8'($urandom), has);
		drain();

		if (cipher_q.size() != 0) begin
			report("expected items left over");
		end
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
